// File: hw/rtl/bvm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte VM package
// Opcodes, beat types, controller command and status structs.
// ----------------------------------------------------------------------------
package bvm_pkg;

    // Field widths
    localparam int PC_W   = 10;
    localparam int NPC_W  = 11;
    localparam int ADDR_W = 10;
    localparam int DATA_W = 8;
    localparam int FUNC_W = 4;

    // Default data memory depth, and compare-subtract steps that reduce a
    // 10-bit address below any depth of at least 16
    localparam int MEM_DEPTH_DEF = 1024;
    localparam int WRAP_STEPS    = 6;

    // Program counter value meaning "ran off the end"
    localparam logic [NPC_W-1:0] PC_END = 11'd1024;

    // Opcodes
    localparam logic [FUNC_W-1:0] OP_SET   = 4'd0;
    localparam logic [FUNC_W-1:0] OP_ADD   = 4'd1;
    localparam logic [FUNC_W-1:0] OP_SUB   = 4'd2;
    localparam logic [FUNC_W-1:0] OP_DIV   = 4'd3;
    localparam logic [FUNC_W-1:0] OP_MUL   = 4'd4;
    localparam logic [FUNC_W-1:0] OP_PRINT = 4'd5;
    localparam logic [FUNC_W-1:0] OP_CMP   = 4'd6;
    localparam logic [FUNC_W-1:0] OP_JUMP  = 4'd7;
    localparam logic [FUNC_W-1:0] OP_GET   = 4'd8;
    localparam logic [FUNC_W-1:0] OP_HALT  = 4'd15;

    // Read port operand select
    localparam logic RSEL_FIRST  = 1'b0;
    localparam logic RSEL_SECOND = 1'b1;

    // Input beat
    typedef struct packed {
        logic [PC_W-1:0]          pc;
        logic [FUNC_W-1:0]        func;
        logic [ADDR_W-1:0]        dest_addr;
        logic [ADDR_W-1:0]        src_a_addr;
        logic [ADDR_W-1:0]        src_b_addr;
        logic signed [DATA_W-1:0] immediate;
        logic signed [DATA_W-1:0] user_value;
    } bvm_item_t;

    // Output beat
    typedef struct packed {
        logic [NPC_W-1:0]         next_pc;
        logic                     print_valid;
        logic signed [DATA_W-1:0] print_value;
        logic                     halted;
        logic                     bad_opcode;
        logic                     div_by_zero;
    } bvm_result_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic clear_wr;
        logic cnt_clr;
        logic cnt_inc;
        logic rd_en;
        logic rd_sel;
        logic cap_a;
        logic cap_b;
        logic exec;
        logic div_step;
        logic mem_wr;
        logic load_out;
    } bvm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic              cnt_clear_last;
        logic              cnt_div_last;
        logic              out_free;
    } bvm_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/bvm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte VM controller
// Sequences memory clear, operand reads, execute, divide steps, write-back
// and result hand-off for one instruction at a time.
// ----------------------------------------------------------------------------
module bvm_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    output logic                 item_ready,
    input  wire bvm_pkg::bvm_status_t sts,
    output bvm_pkg::bvm_cmd_t    cmd
);
    import bvm_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DEC   = 4'd2;
    localparam logic [3:0] ST_RD0   = 4'd3;
    localparam logic [3:0] ST_RD1   = 4'd4;
    localparam logic [3:0] ST_RD2   = 4'd5;
    localparam logic [3:0] ST_EXEC  = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_WR    = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RSEL_FIRST;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (sts.cnt_clear_last)
                begin
                    cmd.cnt_inc = 1'b0;
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DEC;
                end
            end
            ST_DEC:
            begin
                case (sts.op)
                    OP_SET, OP_GET:
                        state_next = ST_WR;
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_PRINT, OP_CMP:
                        state_next = ST_RD0;
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_RD0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RSEL_FIRST;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RSEL_SECOND;
                cmd.cap_a  = 1'b1;
                state_next = (sts.op == OP_PRINT) ? ST_DONE : ST_RD2;
            end
            ST_RD2:
            begin
                cmd.cap_b  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec    = 1'b1;
                cmd.cnt_clr = 1'b1;
                if (sts.op == OP_CMP)
                begin
                    state_next = ST_DONE;
                end
                else if (sts.op == OP_DIV)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_WR;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (sts.cnt_div_last)
                begin
                    state_next = ST_WR;
                end
            end
            ST_WR:
            begin
                cmd.mem_wr = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/bvm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte VM datapath
// Instruction register, data memory, operand registers, ALU, shift-subtract
// divider, compare flag and output register.
// ----------------------------------------------------------------------------
module bvm_datapath #(
    parameter int MEM_DEPTH = bvm_pkg::MEM_DEPTH_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire bvm_pkg::bvm_item_t item,
    input  wire bvm_pkg::bvm_cmd_t  cmd,
    output bvm_pkg::bvm_status_t sts,
    output logic                 result_valid,
    input  wire                  result_ready,
    output bvm_pkg::bvm_result_t result
);
    import bvm_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);

    // Instruction and operand registers (payload, no reset)
    bvm_item_t                ir_reg;
    logic signed [DATA_W-1:0] opa_reg;
    logic signed [DATA_W-1:0] opb_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic signed [DATA_W-1:0] res_next;
    logic [DATA_W-1:0]        rdata_reg;
    logic [DATA_W-1:0]        data_mem [MEM_DEPTH];
    bvm_result_t              out_reg;
    bvm_result_t              out_next;

    // Divider registers
    logic [DATA_W:0]          rem_reg;
    logic [DATA_W:0]          rem_next;
    logic [DATA_W-1:0]        quo_reg;
    logic [DATA_W-1:0]        quo_next;
    logic [DATA_W-1:0]        dvs_reg;
    logic                     neg_reg;
    logic [DATA_W:0]          rem_shift;
    logic [DATA_W-1:0]        quo_signed;
    logic [DATA_W-1:0]        mag_a;
    logic [DATA_W-1:0]        mag_b;

    // Control registers
    logic [AW-1:0]            cnt_reg;
    logic [AW-1:0]            cnt_next;
    logic                     flag_reg;
    logic                     flag_next;
    logic                     dz_reg;
    logic                     dz_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;

    // Address path
    logic [ADDR_W-1:0]        raw_addr;
    logic [ADDR_W-1:0]        wrap_tmp;
    logic [AW-1:0]            mem_addr;
    logic                     mem_we;
    logic [DATA_W-1:0]        mem_wdata;

    logic [2*DATA_W-1:0]      prod;
    logic [NPC_W-1:0]         pc_sum;
    logic [NPC_W-1:0]         pc_inc;

    // Operand address select
    always_comb
    begin
        if (cmd.mem_wr)
        begin
            raw_addr = ir_reg.dest_addr;
        end
        else if (cmd.rd_sel == RSEL_FIRST)
        begin
            raw_addr = ((ir_reg.func == OP_PRINT) || (ir_reg.func == OP_CMP))
                     ? ir_reg.dest_addr : ir_reg.src_a_addr;
        end
        else
        begin
            raw_addr = (ir_reg.func == OP_CMP) ? ir_reg.src_a_addr : ir_reg.src_b_addr;
        end
    end

    // Address modulo depth: compare-subtract of shifted depth
    always_comb
    begin
        wrap_tmp = raw_addr;
        for (int k = WRAP_STEPS - 1; k >= 0; k--)
        begin
            if ({22'd0, wrap_tmp} >= (32'(MEM_DEPTH) << k))
            begin
                wrap_tmp = wrap_tmp - 10'(32'(MEM_DEPTH) << k);
            end
        end
        mem_addr = cmd.clear_wr ? cnt_reg : AW'({22'd0, wrap_tmp});
    end

    // Signed quotient from magnitudes
    assign quo_signed = neg_reg ? (~quo_reg + 8'd1) : quo_reg;

    // Write data select
    always_comb
    begin
        mem_we = cmd.clear_wr || (cmd.mem_wr && !dz_reg);
        case (ir_reg.func)
            OP_SET:  mem_wdata = ir_reg.immediate;
            OP_GET:  mem_wdata = ir_reg.user_value;
            OP_DIV:  mem_wdata = quo_signed;
            default: mem_wdata = res_reg;
        endcase
        if (cmd.clear_wr)
        begin
            mem_wdata = '0;
        end
    end

    // Data memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            data_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= data_mem[mem_addr];
        end
    end

    // ALU
    assign prod = 16'(opa_reg * opb_reg);
    always_comb
    begin
        case (ir_reg.func)
            OP_ADD:  res_next = opa_reg + opb_reg;
            OP_SUB:  res_next = opa_reg - opb_reg;
            OP_MUL:  res_next = prod[DATA_W-1:0];
            default: res_next = res_reg;
        endcase
    end

    // Divider step: shift in one dividend bit, subtract if it fits
    assign mag_a     = opa_reg[DATA_W-1] ? (~opa_reg + 8'd1) : opa_reg;
    assign mag_b     = opb_reg[DATA_W-1] ? (~opb_reg + 8'd1) : opb_reg;
    assign rem_shift = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
    always_comb
    begin
        if (rem_shift >= {1'b0, dvs_reg})
        begin
            rem_next = rem_shift - {1'b0, dvs_reg};
            quo_next = {quo_reg[DATA_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift;
            quo_next = {quo_reg[DATA_W-2:0], 1'b0};
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            ir_reg <= item;
        end
        if (cmd.cap_a)
        begin
            opa_reg <= rdata_reg;
        end
        if (cmd.cap_b)
        begin
            opb_reg <= rdata_reg;
        end
        if (cmd.exec)
        begin
            res_reg <= res_next;
            rem_reg <= '0;
            quo_reg <= mag_a;
            dvs_reg <= mag_b;
            neg_reg <= opa_reg[DATA_W-1] ^ opb_reg[DATA_W-1];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    // Control next values
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        flag_next = flag_reg;
        if (cmd.exec && (ir_reg.func == OP_CMP))
        begin
            flag_next = (opa_reg == opb_reg);
        end

        dz_next = dz_reg;
        if (cmd.load_item)
        begin
            dz_next = 1'b0;
        end
        else if (cmd.exec && (ir_reg.func == OP_DIV))
        begin
            dz_next = (opb_reg == '0);
        end

        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            flag_reg      <= 1'b0;
            dz_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            flag_reg      <= flag_next;
            dz_reg        <= dz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result beat
    always_comb
    begin
        case (ir_reg.func)
            OP_SET, OP_CMP:                 pc_inc = 11'd3;
            OP_ADD, OP_SUB, OP_DIV, OP_MUL: pc_inc = 11'd4;
            OP_PRINT, OP_JUMP, OP_GET:      pc_inc = 11'd2;
            OP_HALT:                        pc_inc = 11'd0;
            default:                        pc_inc = 11'd1;
        endcase
        pc_sum = {1'b0, ir_reg.pc} + pc_inc;

        out_next             = '0;
        out_next.next_pc     = (pc_sum > PC_END) ? PC_END : pc_sum;
        out_next.div_by_zero = dz_reg;
        case (ir_reg.func)
            OP_SET, OP_ADD, OP_SUB, OP_DIV, OP_MUL, OP_CMP, OP_GET:
            begin
                out_next.bad_opcode = 1'b0;
            end
            OP_PRINT:
            begin
                out_next.print_valid = 1'b1;
                out_next.print_value = opa_reg;
            end
            OP_JUMP:
            begin
                if (flag_reg)
                begin
                    out_next.next_pc = {1'b0, ir_reg.dest_addr};
                end
            end
            OP_HALT:
            begin
                out_next.halted = 1'b1;
            end
            default:
            begin
                out_next.bad_opcode = 1'b1;
            end
        endcase
    end

    assign result_valid       = out_valid_reg;
    assign result             = out_reg;
    assign sts.op             = ir_reg.func;
    assign sts.cnt_clear_last = (cnt_reg == AW'(MEM_DEPTH - 1));
    assign sts.cnt_div_last   = (cnt_reg[2:0] == 3'd7);
    assign sts.out_free       = !out_valid_reg || result_ready;

endmodule
`default_nettype wire

// File: hw/rtl/byte_vm_instruction_execute.sv
`timescale 1ns / 1ps
`default_nettype none
// After decode, jump, halt and unknown go straight to the result; set, get write
// back; print reads one operand; cmp reads two, executes; add, sub, mul read,
// execute and write back; div adds eight shift-subtract steps before write-back.
// One instruction at a time; the next is accepted once the result is registered,
// while that result may still wait on result_ready. After reset a clearing pass
// zeroes data memory, one entry per cycle; item_ready stays low until it ends.
// ----------------------------------------------------------------------------
// Byte VM instruction execute
// Executes one instruction of a byte-wide memory-to-memory machine per beat.
// ----------------------------------------------------------------------------
module byte_vm_instruction_execute #(
    parameter int MEM_DEPTH = bvm_pkg::MEM_DEPTH_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    output logic                 item_ready,
    input  wire bvm_pkg::bvm_item_t item,
    output logic                 result_valid,
    input  wire                  result_ready,
    output bvm_pkg::bvm_result_t result
);
    import bvm_pkg::*;

    bvm_cmd_t    cmd;
    bvm_status_t sts;

    // Controller
    bvm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Datapath
    bvm_datapath #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
`default_nettype wire
